>>> design/tbmve_pkg.sv
// Shared types, codes and constants of the menu value editor.
package tbmve_pkg;

    localparam int unsigned NUM_BTN = 3;

    localparam logic [7:0] POS_WRAP = 8'd100;
    localparam logic [7:0] POS_UP   = 8'd100;
    localparam logic [7:0] POS_DOWN = 8'd200;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_VALUE_MIN = 2'd1,
        CFG_VALUE_MAX = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BTN_MENU = 2'd0,
        BTN_UP   = 2'd1,
        BTN_DOWN = 2'd2
    } t_btn;

    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [15:0] VALUE_MIN_RST = 16'd0;
    localparam logic [15:0] VALUE_MAX_RST = 16'd59;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               menu_pressed;
        logic               up_pressed;
        logic               down_pressed;
        logic [31:0]        now_ms;
        logic signed [15:0] load_data;
    } t_item;

    typedef struct packed {
        logic [15:0]        debounce_ms;
        logic signed [15:0] value_min;
        logic signed [15:0] value_max;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0]           value;
        logic [7:0]                   pos;
        logic [NUM_BTN-1:0][31:0]     last_ms;
        logic [NUM_BTN-1:0]           held;
    } t_state;

endpackage

>>> design/tbmve_ifs.sv
// Valid/ready channel interfaces for sample items and result items.
interface tbmve_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic               menu_pressed;
    logic               up_pressed;
    logic               down_pressed;
    logic [31:0]        now_ms;
    logic signed [15:0] load_data;

    modport source (
        output valid, req_type, menu_pressed, up_pressed, down_pressed, now_ms, load_data,
        input  ready
    );
    modport sink (
        input  valid, req_type, menu_pressed, up_pressed, down_pressed, now_ms, load_data,
        output ready
    );
endinterface

interface tbmve_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] edited_value;
    logic [7:0]         menu_position;
    logic               beep;

    modport source (
        output valid, edited_value, menu_position, beep,
        input  ready
    );
    modport sink (
        input  valid, edited_value, menu_position, beep,
        output ready
    );
endinterface

>>> design/tbmve_step.sv
// Next-state logic for one item: debounce, menu/up/down actions, load and clear.
module tbmve_step (
    input  tbmve_pkg::t_item  i_item,
    input  tbmve_pkg::t_cfg   i_cfg,
    input  tbmve_pkg::t_state i_state,
    output tbmve_pkg::t_state o_state,
    output logic              o_beep
);
    import tbmve_pkg::*;

    logic [NUM_BTN-1:0] pressed;
    logic [NUM_BTN-1:0] fire;
    logic [NUM_BTN-1:0] held_n;
    logic [NUM_BTN-1:0][31:0] last_n;
    logic [31:0]        elapsed [NUM_BTN];
    logic [7:0]         pos_menu;
    logic [7:0]         pos_inc;
    logic [7:0]         pos_up;
    logic signed [15:0] val_up;
    logic signed [16:0] sum_up;
    logic signed [16:0] sum_dn;

    assign pressed[BTN_MENU] = i_item.menu_pressed;
    assign pressed[BTN_UP]   = i_item.up_pressed;
    assign pressed[BTN_DOWN] = i_item.down_pressed;

    // each button is independent: debounce against its own last accepted time
    always_comb begin
        for (int b = 0; b < NUM_BTN; b++) begin
            elapsed[b] = i_item.now_ms - i_state.last_ms[b];
            fire[b]    = 1'b0;
            held_n[b]  = i_state.held[b];
            last_n[b]  = i_state.last_ms[b];
            if (pressed[b]) begin
                if (elapsed[b] >= {16'd0, i_cfg.debounce_ms}) begin
                    last_n[b] = i_item.now_ms;
                    fire[b]   = ~i_state.held[b];
                    held_n[b] = 1'b1;
                end
            end else begin
                held_n[b] = 1'b0;
            end
        end
    end

    // menu, then up, then down: each sees what the one before left
    always_comb begin
        pos_inc  = i_state.pos + 8'd1;
        pos_menu = i_state.pos;
        if (fire[BTN_MENU]) begin
            pos_menu = (pos_inc == POS_WRAP) ? 8'd0 : pos_inc;
        end

        sum_up = {i_state.value[15], i_state.value} + 17'sd1;
        val_up = i_state.value;
        pos_up = pos_menu;
        if (fire[BTN_UP]) begin
            val_up = (sum_up > $signed({i_cfg.value_max[15], i_cfg.value_max})) ?
                     i_cfg.value_min : sum_up[15:0];
            if (pos_menu == 8'd0) begin
                pos_up = POS_UP;
            end
        end

        sum_dn = {val_up[15], val_up} - 17'sd1;
        o_state = i_state;
        o_beep  = 1'b0;
        unique case (t_req'(i_item.req_type))
            REQ_SAMPLE: begin
                o_state.last_ms = last_n;
                o_state.held    = held_n;
                o_state.value   = val_up;
                o_state.pos     = pos_up;
                if (fire[BTN_DOWN]) begin
                    o_state.value =
                        (sum_dn < $signed({i_cfg.value_min[15], i_cfg.value_min})) ?
                        i_cfg.value_max : sum_dn[15:0];
                    if (pos_up == 8'd0) begin
                        o_state.pos = POS_DOWN;
                    end
                end
                o_beep = |fire;
            end
            REQ_LOAD:  o_state.value = i_item.load_data;
            REQ_CLEAR: o_state.pos   = 8'd0;
            default:   o_state = i_state;
        endcase
    end
endmodule

>>> design/three_button_menu_value_editor_top.sv
// Top level of the three-button menu value editor.
// One result item comes out for every input item: an item is taken into an input
// register, its whole update (debounce of the menu, up and down buttons, position
// and value step, load or clear) is worked out combinationally into the state and
// the result register. A new item is accepted every clock while the result side
// keeps taking items; once both registers hold an item, a stall on the result side
// drops the input ready in the same cycle. Write the configuration only while no
// item is in flight.
module three_button_menu_value_editor_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tbmve_in_if.sink             i_in,
    tbmve_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  tbmve_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import tbmve_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_item  r_in;
    t_item  n_in;
    logic   r_in_valid;
    logic   r_out_valid;
    logic signed [15:0] r_out_value;
    logic [7:0]         r_out_pos;
    logic               r_out_beep;
    logic   n_beep;
    logic   advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign n_in.req_type     = i_in.req_type;
    assign n_in.menu_pressed = i_in.menu_pressed;
    assign n_in.up_pressed   = i_in.up_pressed;
    assign n_in.down_pressed = i_in.down_pressed;
    assign n_in.now_ms       = i_in.now_ms;
    assign n_in.load_data    = i_in.load_data;

    tbmve_step u_step (
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_beep  (n_beep)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= DEBOUNCE_RST;
            r_cfg.value_min   <= VALUE_MIN_RST;
            r_cfg.value_max   <= VALUE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:  r_cfg.debounce_ms <= i_cfg_data;
                CFG_VALUE_MIN: r_cfg.value_min   <= i_cfg_data;
                CFG_VALUE_MAX: r_cfg.value_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= n_in;
        end
        if (advance) begin
            r_out_value <= n_state.value;
            r_out_pos   <= n_state.pos;
            r_out_beep  <= n_beep;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.edited_value  = r_out_value;
    assign o_out.menu_position = r_out_pos;
    assign o_out.beep          = r_out_beep;

    a_load_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.req_type == REQ_LOAD |=> r_out_value == $past(r_in.load_data))
        else $error("load item did not set the edited value");

    a_no_beep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.req_type != REQ_SAMPLE |=> !r_out_beep)
        else $error("beep on a non-sample item");

    a_clear_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.req_type == REQ_CLEAR |=> r_out_pos == 8'd0)
        else $error("clear item left a nonzero position");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("pending item lost or overwritten");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an item");
endmodule
